[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define QPHT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define QPHT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define QPHT_ASSERT_IMP(lbl, ante, cons, msg)
`define QPHT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/qpht_pkg.sv]
// ----------------------------------------------------------------------------
// qpht_pkg
// Widths, codes and defaults for the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
package qpht_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_SLOTS     = 256;
   localparam int DEF_KEY_BYTES = 8;

   // Port field widths
   localparam int CMD_W        = 2;
   localparam int KEY_IN_W     = 64;
   localparam int STATUS_W     = 2;
   localparam int SLOT_OUT_W   = 8;
   localparam int COUNT_W      = 9;
   localparam int COLL_W       = 32;
   localparam int TABLE_SIZE_W = 9;

   // Word widths, packed from the lowest bit up, padded to whole bytes
   localparam int REQ_FIELDS_W = CMD_W + KEY_IN_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + SLOT_OUT_W + COUNT_W + COLL_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Byte sum of up to eight bytes fits in eleven bits
   localparam int SUM_W = 11;

   localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 9'd251;

   typedef logic [1:0] mark_type;
   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mark_type MARK_EMPTY   = 2'd0;
   localparam mark_type MARK_USED    = 2'd1;
   localparam mark_type MARK_DELETED = 2'd2;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_FIND   = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_MISSING = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

endpackage

[rtl/quadratic_probe_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table, quadratic probing, lazy deletion.
//
//   channel   ports        direction   word fields (low bit up)
//   request   req_t*       in          cmd, key
//   response  rsp_t*       out         status, slot, item_count,
//                                      collision_count, rehash_needed
//   config    csr_we/wdata in          table_size
//
// One item at a time: an accept step, restoring modulo for the home slot,
// then per probe a slot RAM registered read and a compare, then a step to
// post the response. A miss on find or remove walks all probes of the active
// table size, clamped to 1 .. SLOTS; an unknown command skips modulo and
// probing.
// After reset the slot RAM is swept to empty, every slot, with req_tready low.
// The response sits in an output register; a stalled rsp holds the next
// finished item in the response state until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_probe_hash_table_unit #(
   parameter int SLOTS     = qpht_pkg::DEF_SLOTS,
   parameter int KEY_BYTES = qpht_pkg::DEF_KEY_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   // cmd [1:0], key [65:2]
   input  logic [qpht_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status [1:0], slot [9:2], item_count [18:10], collision_count [50:19],
   // rehash_needed [51]
   output logic [qpht_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [qpht_pkg::TABLE_SIZE_W-1:0]   csr_wdata
);

   import qpht_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SIZE_W = $clog2(SLOTS + 1);
   localparam int CMP_W  = (SIZE_W > TABLE_SIZE_W) ? SIZE_W : TABLE_SIZE_W;
   localparam int UNIT_W = CMP_W + SUM_W;
   localparam int K_W    = $clog2(SUM_W);
   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int MEM_W  = KEY_W + 2;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   // Control registers
   logic [2:0]              state_ff, state_in;
   logic [SLOT_W-1:0]       p_ff, p_in;
   logic [COUNT_W-1:0]      live_ff, live_in;
   logic [COLL_W-1:0]       coll_ff, coll_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TABLE_SIZE_W-1:0] table_size_ff, table_size_in;

   // Working registers
   cmd_type                 cmd_ff, cmd_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [CMP_W-1:0]        inc_ff, inc_in;
   logic [CMP_W-1:0]        cnt_ff, cnt_in;
   status_type              status_ff, status_in;
   logic [SLOT_OUT_W-1:0]   slot_ff, slot_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // Request word fields
   cmd_type                 req_cmd;
   logic [KEY_IN_W-1:0]     req_key;
   logic [KEY_W-1:0]        req_key_m;
   logic [SUM_W-1:0]        byte_sum;

   // Active size and shared compare-subtract unit
   logic [CMP_W-1:0]        ts_ext;
   logic [CMP_W-1:0]        size_act;
   logic [UNIT_W-1:0]       unit_a, unit_b, unit_rhs, unit_lhs, unit_res;
   logic [CMP_W:0]          inc_sum;
   logic [CMP_W-1:0]        cnt_next;

   // Slot RAM
   logic                    ram_we;
   logic [MEM_W-1:0]        ram_wdata;
   logic [MEM_W-1:0]        ram_rdata;
   mark_type                rd_mark;
   logic [KEY_W-1:0]        rd_key;
   logic                    rehash;

   assign req_cmd   = req_tdata[CMD_W-1:0];
   assign req_key   = req_tdata[CMD_W +: KEY_IN_W];
   assign req_key_m = req_key[KEY_W-1:0];

   always_comb begin
      byte_sum = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         byte_sum = byte_sum + SUM_W'(req_key_m[8*b +: 8]);
      end
   end

   // Clamp size to 1 .. SLOTS
   assign ts_ext = CMP_W'(table_size_ff);
   always_comb begin
      if (ts_ext == '0) begin
         size_act = CMP_W'(1);
      end else if (ts_ext > CMP_W'(SLOTS)) begin
         size_act = CMP_W'(SLOTS);
      end else begin
         size_act = ts_ext;
      end
   end

   // Shared unit: (a + b), subtract rhs when not below it
   always_comb begin
      if (state_ff == S_MOD) begin
         unit_a   = UNIT_W'(acc_ff);
         unit_b   = '0;
         unit_rhs = UNIT_W'(size_act) << k_ff;
      end else begin
         unit_a   = UNIT_W'(p_ff);
         unit_b   = UNIT_W'(inc_ff);
         unit_rhs = UNIT_W'(size_act);
      end
      unit_lhs = unit_a + unit_b;
      unit_res = (unit_lhs >= unit_rhs) ? (unit_lhs - unit_rhs) : unit_lhs;
   end

   assign inc_sum  = (CMP_W + 1)'(inc_ff) + (CMP_W + 1)'(2);
   assign cnt_next = cnt_ff + CMP_W'(1);
   assign rd_mark  = ram_rdata[KEY_W +: 2];
   assign rd_key   = ram_rdata[KEY_W-1:0];
   assign rehash   = UNIT_W'({live_ff, 1'b0}) > UNIT_W'(size_act);

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      live_in       = live_ff;
      coll_in       = coll_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      acc_in        = acc_ff;
      k_in          = k_ff;
      inc_in        = inc_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_wdata     = {MARK_EMPTY, KEY_W'(0)};
      table_size_in = csr_we ? csr_wdata : table_size_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            p_in   = p_ff + SLOT_W'(1);
            if (p_ff == SLOT_W'(SLOTS - 1)) begin
               p_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               key_in = req_key_m;
               acc_in = byte_sum;
               k_in   = K_W'(SUM_W - 1);
               if (req_cmd inside {CMD_INSERT, CMD_FIND, CMD_REMOVE}) begin
                  state_in = S_MOD;
               end else begin
                  status_in = ST_MISSING;
                  slot_in   = '0;
                  state_in  = S_RESP;
               end
            end
         end
         S_MOD: begin
            // One restoring step per cycle, high shift first
            acc_in = SUM_W'(unit_res);
            if (k_ff == '0) begin
               p_in     = SLOT_W'(unit_res);
               inc_in   = CMP_W'(1);
               cnt_in   = '0;
               state_in = S_READ;
            end else begin
               k_in = k_ff - K_W'(1);
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cmd_ff == CMD_INSERT && rd_mark != MARK_USED) begin
               ram_we    = 1'b1;
               ram_wdata = {MARK_USED, key_ff};
               if (live_ff != '1) begin
                  live_in = live_ff + COUNT_W'(1);
               end
               status_in = ST_OK;
               slot_in   = SLOT_OUT_W'(p_ff);
               state_in  = S_RESP;
            end else if (cmd_ff != CMD_INSERT && rd_mark == MARK_USED &&
                         rd_key == key_ff) begin
               if (cmd_ff == CMD_REMOVE) begin
                  ram_we    = 1'b1;
                  ram_wdata = {MARK_DELETED, key_ff};
                  if (live_ff != '0) begin
                     live_in = live_ff - COUNT_W'(1);
                  end
               end
               status_in = ST_OK;
               slot_in   = SLOT_OUT_W'(p_ff);
               state_in  = S_RESP;
            end else begin
               if (cmd_ff == CMD_INSERT && coll_ff != '1) begin
                  coll_in = coll_ff + COLL_W'(1);
               end
               if (cnt_next == size_act) begin
                  status_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_MISSING;
                  slot_in   = '0;
                  state_in  = S_RESP;
               end else begin
                  // Advance: p += 2i+1, both kept below size
                  p_in   = SLOT_W'(unit_res);
                  cnt_in = cnt_next;
                  if (size_act == CMP_W'(1)) begin
                     inc_in = '0;
                  end else if (inc_sum >= (CMP_W + 1)'(size_act)) begin
                     inc_in = CMP_W'(inc_sum - (CMP_W + 1)'(size_act));
                  end else begin
                     inc_in = CMP_W'(inc_sum);
                  end
                  state_in = S_READ;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({rehash, coll_ff, live_ff, slot_ff, status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         p_ff          <= '0;
         live_ff       <= '0;
         coll_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         state_ff      <= state_in;
         p_ff          <= p_in;
         live_ff       <= live_in;
         coll_ff       <= coll_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      acc_ff      <= acc_in;
      k_ff        <= k_in;
      inc_ff      <= inc_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   qpht_ram #(
      .WIDTH (MEM_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (p_ff),
      .wr_data (ram_wdata),
      .rd_addr (p_ff),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `QPHT_ASSERT_IMP(a_probe_in_range, (state_ff == S_READ || state_ff == S_CHECK), (CMP_W'(p_ff) < size_act), "probe slot not below table size")
   `QPHT_ASSERT_IMP(a_write_states, ram_we, (state_ff == S_CLEAR || state_ff == S_CHECK), "slot RAM written outside sweep or compare")
   `QPHT_ASSERT_NXT(a_live_hold, (state_ff != S_CHECK), $stable(live_ff), "item count moved outside compare")
   `QPHT_ASSERT_NXT(a_busy_after_accept, (req_tvalid && req_tready), (state_ff != S_IDLE), "accepted word left block idle")

endmodule

[rtl/qpht_ram.sv]
// ----------------------------------------------------------------------------
// qpht_ram
// Generic RAM with separate write and read addresses, one write port, registered read.
// ----------------------------------------------------------------------------
module qpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
